// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is low
`define QPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qps assertion failed");

// property checked on every rising edge, reset included
`define QPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qps assertion failed");

`endif

// ===== hdl/qps_pkg.sv =====
// types, codes and constants of the quadrature position spoofer
// no dependencies; used by every module of the block
package qps_pkg;

    // item commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // bus register numbers
    localparam logic [7:0] RD_POS_HI = 8'h00;
    localparam logic [7:0] RD_POS_LO = 8'h01;
    localparam logic [7:0] RD_ZERO   = 8'h02;
    localparam logic [7:0] RD_EVENTS = 8'h03;
    localparam logic [7:0] WR_CMD    = 8'h10;
    localparam logic [7:0] WR_TARGET = 8'h11;
    localparam logic [7:0] RD_UNMAPPED = 8'hFF;

    // command register values
    localparam logic [7:0] CMDV_HOME  = 8'h01;
    localparam logic [7:0] CMDV_CLICK = 8'h04;

    // event flag bits
    localparam int EVT_CW    = 0;
    localparam int EVT_CCW   = 1;
    localparam int EVT_CLICK = 2;

    localparam logic [9:0] TICK_MAX = 10'h3FF;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_PHASE = 2'd0;
    localparam logic [1:0] CFG_CLICK = 2'd1;
    localparam logic [1:0] CFG_BEEP  = 2'd2;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
    localparam logic [9:0] CLICK_TICKS_RST = 10'd100;
    localparam logic [9:0] BEEP_TICKS_RST  = 10'd50;

    typedef enum logic [4:0] {
        ACT_IDLE     = 5'b00001,
        ACT_BEEP     = 5'b00010,
        ACT_CLICK_HI = 5'b00100,
        ACT_CLICK_LO = 5'b01000,
        ACT_STEP     = 5'b10000
    } t_action;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] reg_addr;
        logic [7:0] write_hi;
        logic [7:0] write_lo;
        logic [1:0] write_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       enc_a;
        logic       enc_b;
        logic       button;
        logic       buzzer_n;
        logic       busy_res;
    } t_out_item;

    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [9:0] click_ticks;
        logic [9:0] beep_ticks;
    } t_cfg;

    // quadrature pin levels {a, b} for a phase in either direction
    function automatic logic [1:0] phase_pins(input logic cw, input logic [1:0] idx);
        logic [1:0] ab;
        if (cw) begin
            case (idx)
                2'd0:    ab = 2'b01;
                2'd1:    ab = 2'b11;
                2'd2:    ab = 2'b10;
                default: ab = 2'b00;
            endcase
        end else begin
            case (idx)
                2'd0:    ab = 2'b00;
                2'd1:    ab = 2'b10;
                2'd2:    ab = 2'b11;
                default: ab = 2'b01;
            endcase
        end
        return ab;
    endfunction

endpackage

// ===== hdl/qps_apb_regs.sv =====
// configuration register file behind an apb-style port
// depends on qps_pkg
module qps_apb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output qps_pkg::t_cfg      o_cfg
);
    import qps_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= PHASE_TICKS_RST;
            r_cfg.click_ticks <= CLICK_TICKS_RST;
            r_cfg.beep_ticks  <= BEEP_TICKS_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                CFG_PHASE: r_cfg.phase_ticks <= pwdata[7:0];
                CFG_CLICK: r_cfg.click_ticks <= pwdata[9:0];
                CFG_BEEP:  r_cfg.beep_ticks  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            CFG_PHASE: prdata = {24'd0, r_cfg.phase_ticks};
            CFG_CLICK: prdata = {22'd0, r_cfg.click_ticks};
            CFG_BEEP:  prdata = {22'd0, r_cfg.beep_ticks};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/qps_core.sv =====
// spoofer state and the single-pass update for one item
// depends on qps_pkg
module qps_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  qps_pkg::t_in_item   i_item,
    input  qps_pkg::t_cfg       i_cfg,
    output qps_pkg::t_out_item  o_result
);
    import qps_pkg::*;

    logic [15:0] r_position, n_position;
    logic [15:0] r_target, n_target;
    logic        r_click_pend, n_click_pend;
    logic        r_beep_pend, n_beep_pend;
    logic [2:0]  r_events, n_events;
    t_action     r_action, n_action;
    logic [1:0]  r_phase, n_phase;
    logic        r_cw, n_cw;
    logic [9:0]  r_tick, n_tick;
    logic        r_a, n_a, r_b, n_b, r_btn, n_btn, r_buz, n_buz;
    logic [7:0]  w_rd;
    logic [9:0]  w_hold;
    logic [1:0]  w_ab;

    // hold length of the running action
    always_comb begin
        unique case (r_action)
            ACT_BEEP:                  w_hold = i_cfg.beep_ticks;
            ACT_CLICK_HI, ACT_CLICK_LO: w_hold = i_cfg.click_ticks;
            default:                   w_hold = {2'd0, i_cfg.phase_ticks};
        endcase
    end

    always_comb begin
        n_position   = r_position;
        n_target     = r_target;
        n_click_pend = r_click_pend;
        n_beep_pend  = r_beep_pend;
        n_events     = r_events;
        n_action     = r_action;
        n_phase      = r_phase;
        n_cw         = r_cw;
        n_tick       = r_tick;
        n_a          = r_a;
        n_b          = r_b;
        n_btn        = r_btn;
        n_buz        = r_buz;
        w_rd         = 8'd0;
        w_ab         = 2'b00;

        unique case (i_item.command)
            CMD_READ: begin
                case (i_item.reg_addr)
                    RD_POS_HI: w_rd = r_position[15:8];
                    RD_POS_LO: w_rd = r_position[7:0];
                    RD_ZERO:   w_rd = 8'd0;
                    RD_EVENTS: begin
                        w_rd     = {5'd0, r_events};
                        n_events = 3'd0;
                    end
                    default:   w_rd = RD_UNMAPPED;
                endcase
            end
            CMD_WRITE: begin
                if (i_item.write_len != 2'd0) begin
                    if (i_item.reg_addr == WR_CMD) begin
                        n_beep_pend = 1'b1;
                        if (i_item.write_hi == CMDV_HOME) begin
                            n_target   = 16'd0;
                            n_position = 16'd0;
                            // a running step is dropped, pins stay
                            if (r_action == ACT_STEP) begin
                                n_action = ACT_IDLE;
                                n_phase  = 2'd0;
                                n_tick   = 10'd0;
                            end
                        end else if (i_item.write_hi == CMDV_CLICK) begin
                            n_click_pend = 1'b1;
                        end
                    end else if (i_item.reg_addr == WR_TARGET && i_item.write_len[1]) begin
                        n_beep_pend = 1'b1;
                        n_target    = {i_item.write_hi, i_item.write_lo};
                    end
                end
            end
            CMD_TICK: begin
                // end of the current phase
                if (r_action != ACT_IDLE && r_tick >= w_hold) begin
                    unique case (r_action)
                        ACT_BEEP: begin
                            n_buz    = 1'b1;
                            n_action = ACT_IDLE;
                        end
                        ACT_CLICK_HI: begin
                            n_btn    = 1'b0;
                            n_action = ACT_CLICK_LO;
                            n_tick   = 10'd0;
                        end
                        ACT_CLICK_LO: begin
                            n_events[EVT_CLICK] = 1'b1;
                            n_action = ACT_IDLE;
                        end
                        ACT_STEP: begin
                            if (r_phase != 2'd3) begin
                                n_phase = r_phase + 2'd1;
                                w_ab    = phase_pins(r_cw, n_phase);
                                n_a     = w_ab[1];
                                n_b     = w_ab[0];
                                n_tick  = 10'd0;
                            end else begin
                                n_phase    = 2'd0;
                                n_position = r_cw ? r_position + 16'd1 : r_position - 16'd1;
                                if (n_position == r_target) begin
                                    if (r_cw) begin
                                        n_events[EVT_CW] = 1'b1;
                                    end else begin
                                        n_events[EVT_CCW] = 1'b1;
                                    end
                                end
                                n_action = ACT_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                // start the next piece of work
                if (n_action == ACT_IDLE) begin
                    n_tick = 10'd0;
                    if (n_beep_pend) begin
                        n_beep_pend = 1'b0;
                        n_buz       = 1'b0;
                        n_action    = ACT_BEEP;
                    end else if (n_click_pend) begin
                        n_click_pend = 1'b0;
                        n_btn        = 1'b1;
                        n_action     = ACT_CLICK_HI;
                    end else if (n_position != r_target) begin
                        n_cw     = $signed(n_position) < $signed(r_target);
                        n_phase  = 2'd0;
                        w_ab     = phase_pins(n_cw, 2'd0);
                        n_a      = w_ab[1];
                        n_b      = w_ab[0];
                        n_action = ACT_STEP;
                    end
                end
                // count the tick, saturating
                if (n_action != ACT_IDLE && n_tick != TICK_MAX) begin
                    n_tick = n_tick + 10'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= 16'd0;
            r_target     <= 16'd0;
            r_click_pend <= 1'b0;
            r_beep_pend  <= 1'b1;
            r_events     <= 3'd0;
            r_action     <= ACT_IDLE;
            r_phase      <= 2'd0;
            r_cw         <= 1'b0;
            r_tick       <= 10'd0;
            r_a          <= 1'b0;
            r_b          <= 1'b0;
            r_btn        <= 1'b0;
            r_buz        <= 1'b1;
        end else if (i_fire) begin
            r_position   <= n_position;
            r_target     <= n_target;
            r_click_pend <= n_click_pend;
            r_beep_pend  <= n_beep_pend;
            r_events     <= n_events;
            r_action     <= n_action;
            r_phase      <= n_phase;
            r_cw         <= n_cw;
            r_tick       <= n_tick;
            r_a          <= n_a;
            r_b          <= n_b;
            r_btn        <= n_btn;
            r_buz        <= n_buz;
        end
    end

    assign o_result.read_data = w_rd;
    assign o_result.enc_a     = n_a;
    assign o_result.enc_b     = n_b;
    assign o_result.button    = n_btn;
    assign o_result.buzzer_n  = n_buz;
    assign o_result.busy_res  = (n_action != ACT_IDLE);

endmodule

// ===== hdl/quadrature_position_spoofer.sv =====
// top level of the quadrature position spoofer: item registers and handshakes
// depends on qps_pkg, qps_apb_regs and qps_core
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready   o_out_item (t_out_item)
//  cfg       input      psel penable pwrite pready  paddr pwdata / prdata
//
// one item per cycle while results are taken; items pass the item register first
// the item register feeds the core, which updates state and loads the result
// register in the same cycle; no clearing pass, items are taken right after reset
// while the result register waits, one more item is held in the item register
// synchronous active-low reset restores the start-up state with a beep queued
module quadrature_position_spoofer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  qps_pkg::t_in_item   i_in_item,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output qps_pkg::t_out_item  o_out_item,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import qps_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_move;
    t_cfg      w_cfg;
    t_out_item w_result;

    // item register moves into the result register when that one is free
    assign w_move      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_move;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    qps_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_move),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_item <= w_result;
        end
    end

endmodule

// ===== hdl/qps_checker.sv =====
// port-level checker for the quadrature position spoofer, bound to the top
// depends on qps_pkg and assert_macros.svh
`include "assert_macros.svh"

module qps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input qps_pkg::t_out_item  o_out_item
);
    import qps_pkg::*;

    // result register is empty right after reset
    `QPS_ASSERT_ALWAYS(a_out_empty_after_rst, i_clk, !i_rst_n |=> !o_out_valid)

    // with no result waiting the item side is always open
    `QPS_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // a stalled result holds
    `QPS_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))

    // buzzer and button are only active while work runs
    `QPS_ASSERT(a_idle_pins, i_clk, i_rst_n,
        o_out_valid && !o_out_item.busy_res |-> o_out_item.buzzer_n && !o_out_item.button)

    // beep and click never overlap
    `QPS_ASSERT(a_beep_click_excl, i_clk, i_rst_n,
        o_out_valid && !o_out_item.buzzer_n |-> !o_out_item.button)

endmodule

bind quadrature_position_spoofer qps_checker u_qps_checker (.*);
